### hdl/ed_pkg.sv
// ============================================================================
// ed_pkg
// Shared widths, limits and controller/datapath link types for the
// Euclidean distance engine.
// ============================================================================
package ed_pkg;

    localparam int ElemW     = 16;                 // Q8.8 element
    localparam int MagW      = 16;                 // |a - b| never exceeds 65535
    localparam int SqW       = 2 * MagW;           // Q16.16 square
    localparam int SumW      = 44;                 // running sum of squares
    localparam int DistW     = SumW / 2;           // floor sqrt width
    localparam int RootSteps = DistW;              // one root bit per step
    localparam int RemW      = DistW + 3;          // partial remainder
    localparam int StepW     = $clog2(RootSteps);

    localparam logic [SumW-1:0] SumMax = {SumW{1'b1}};

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input item taken this cycle
        logic root_step;  // one square root iteration
        logic out_load;   // move finished result into output register
    } ed_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic fin;        // last item of a vector reached the accumulator
    } ed_sts_t;

endpackage

### hdl/ed_ctrl.sv
// ============================================================================
// ed_ctrl
// Sequencer: input gating, drain of the square pipeline, square root
// iteration count and output valid.
// ============================================================================
module ed_ctrl
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_valid,
    input  logic            last,
    input  logic            out_stall,
    input  ed_pkg::ed_sts_t sts,
    output logic            in_stall,
    output logic            out_valid,
    output ed_pkg::ed_cmd_t cmd
);

    typedef enum logic [1:0] {
        S_RUN,
        S_DRAIN,
        S_ROOT,
        S_LOAD
    } state_t;

    state_t                        state_reg;
    state_t                        state_next;
    logic [ed_pkg::StepW-1:0]      cnt_reg;
    logic [ed_pkg::StepW-1:0]      cnt_next;
    logic                          out_valid_reg;
    logic                          out_valid_next;

    assign in_stall  = (state_reg != S_RUN);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        cmd.accept    = in_valid && (state_reg == S_RUN);
        cmd.root_step = (state_reg == S_ROOT);
        cmd.out_load  = (state_reg == S_LOAD) && (!out_valid_reg || !out_stall);
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;

        if (out_valid_reg && !out_stall)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            S_RUN:
            begin
                if (cmd.accept && last)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                if (sts.fin)
                begin
                    state_next = S_ROOT;
                    cnt_next   = ed_pkg::StepW'(ed_pkg::RootSteps - 1);
                end
            end
            S_ROOT:
            begin
                if (cnt_reg == '0)
                begin
                    state_next = S_LOAD;
                end
                else
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            S_LOAD:
            begin
                if (cmd.out_load)
                begin
                    out_valid_next = 1'b1;
                    state_next     = S_RUN;
                end
            end
            default:
            begin
                state_next = S_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_RUN;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

### hdl/ed_dp.sv
// ============================================================================
// ed_dp
// Datapath: difference magnitude, square, saturating accumulate, and a
// bit-per-cycle restoring square root, plus the output register.
// ============================================================================
module ed_dp
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  ed_pkg::ed_cmd_t                  cmd,
    input  logic signed [ed_pkg::ElemW-1:0]  elem_a,
    input  logic signed [ed_pkg::ElemW-1:0]  elem_b,
    input  logic                             last,
    output ed_pkg::ed_sts_t                  sts,
    output logic        [ed_pkg::DistW-1:0]  distance,
    output logic        [ed_pkg::SumW-1:0]   sum_squares
);

    // stage 1: |a - b|
    logic signed [ed_pkg::ElemW:0] diff;
    logic        [ed_pkg::ElemW:0] diff_abs;
    logic                          v1_reg;
    logic                          last1_reg;
    logic        [ed_pkg::MagW-1:0] mag_reg;

    // stage 2: square
    logic                          v2_reg;
    logic                          last2_reg;
    logic        [ed_pkg::SqW-1:0] sq_reg;

    // stage 3: accumulate
    logic [ed_pkg::SumW:0]         sum_ext;
    logic [ed_pkg::SumW-1:0]       sum_sat;
    logic [ed_pkg::SumW-1:0]       sum_reg;
    logic [ed_pkg::SumW-1:0]       hold_reg;

    // square root
    logic [ed_pkg::SumW-1:0]       rad_reg;
    logic [ed_pkg::RemW-1:0]       rem_reg;
    logic [ed_pkg::RemW-1:0]       rem_next;
    logic [ed_pkg::DistW-1:0]      root_reg;
    logic [ed_pkg::DistW-1:0]      root_next;
    logic [ed_pkg::RemW-1:0]       rem_sh;
    logic [ed_pkg::RemW-1:0]       trial;

    // output register
    logic [ed_pkg::DistW-1:0]      dist_out_reg;
    logic [ed_pkg::SumW-1:0]       sum_out_reg;

    assign diff     = {elem_a[ed_pkg::ElemW-1], elem_a} - {elem_b[ed_pkg::ElemW-1], elem_b};
    assign diff_abs = diff[ed_pkg::ElemW] ? (~diff + 1'b1) : diff;

    assign sum_ext = {1'b0, sum_reg} + (ed_pkg::SumW + 1)'(sq_reg);
    assign sum_sat = sum_ext[ed_pkg::SumW] ? ed_pkg::SumMax : sum_ext[ed_pkg::SumW-1:0];

    assign sts.fin = v2_reg && last2_reg;

    // one root bit per step, two radicand bits shifted in
    always_comb
    begin
        rem_sh = {rem_reg[ed_pkg::RemW-3:0], rad_reg[ed_pkg::SumW-1 -: 2]};
        trial  = ed_pkg::RemW'({root_reg, 2'b01});
        if (rem_sh >= trial)
        begin
            rem_next  = rem_sh - trial;
            root_next = {root_reg[ed_pkg::DistW-2:0], 1'b1};
        end
        else
        begin
            rem_next  = rem_sh;
            root_next = {root_reg[ed_pkg::DistW-2:0], 1'b0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg  <= 1'b0;
            v2_reg  <= 1'b0;
            sum_reg <= '0;
        end
        else
        begin
            v1_reg <= cmd.accept;
            v2_reg <= v1_reg;
            if (v2_reg)
            begin
                sum_reg <= last2_reg ? '0 : sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            mag_reg   <= diff_abs[ed_pkg::MagW-1:0];
            last1_reg <= last;
        end
        if (v1_reg)
        begin
            sq_reg    <= mag_reg * mag_reg;
            last2_reg <= last1_reg;
        end
        if (sts.fin)
        begin
            hold_reg <= sum_sat;
            rad_reg  <= sum_sat;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (cmd.root_step)
        begin
            rad_reg  <= {rad_reg[ed_pkg::SumW-3:0], 2'b00};
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
        if (cmd.out_load)
        begin
            dist_out_reg <= root_reg;
            sum_out_reg  <= hold_reg;
        end
    end

    assign distance    = dist_out_reg;
    assign sum_squares = sum_out_reg;

endmodule

### hdl/euclidean_distance.sv
// ============================================================================
// euclidean_distance
// Streaming Euclidean distance / magnitude engine, signed Q8.8 elements.
// ============================================================================
// Usage:
//   Input channel (in_valid / in_stall): one element pair elem_a, elem_b per
//   item; last marks the final pair of a vector. Hold elem_b at zero to get
//   the magnitude of the elem_a vector.
//   Output channel (out_valid / out_stall): one item per vector, carrying
//   distance = floor(sqrt(sum)) in Q14.8 and sum_squares, the sum of squared
//   differences in Q28.16, saturated at 2^44 - 1.
// Throughput: items not marked last go in at one per cycle through a
//   three-stage difference / square / accumulate pipe. After a last item the
//   input stalls while the pipe drains, the square root runs one bit per
//   cycle and the result is loaded into the output register; this load
//   waits while the output register is still held by the previous result.
// Stall: the output register holds its item while out_stall is high; new
//   input items are still taken up to a last item, whose result then waits.
// Reset: clears the running sum, the pipe and the output valid.
// ============================================================================
module euclidean_distance
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             in_valid,
    output logic                             in_stall,
    input  logic signed [ed_pkg::ElemW-1:0]  elem_a,
    input  logic signed [ed_pkg::ElemW-1:0]  elem_b,
    input  logic                             last,
    output logic                             out_valid,
    input  logic                             out_stall,
    output logic        [ed_pkg::DistW-1:0]  distance,
    output logic        [ed_pkg::SumW-1:0]   sum_squares
);

    ed_pkg::ed_cmd_t cmd;
    ed_pkg::ed_sts_t sts;

    // sequencer
    ed_ctrl u_ctrl
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .last      (last),
        .out_stall (out_stall),
        .sts       (sts),
        .in_stall  (in_stall),
        .out_valid (out_valid),
        .cmd       (cmd)
    );

    // arithmetic
    ed_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .elem_a      (elem_a),
        .elem_b      (elem_b),
        .last        (last),
        .sts         (sts),
        .distance    (distance),
        .sum_squares (sum_squares)
    );

    // a vector end closes the input until its result is loaded
    a_last_closes: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && last) |=> in_stall)
        else $error("input open after last item");

    // result is the floor square root of the sum
    a_root_low: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((46'(distance) * 46'(distance)) <= 46'(sum_squares)))
        else $error("distance too large");

    a_root_high: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |->
            (((46'(distance) + 46'd1) * (46'(distance) + 46'd1)) > 46'(sum_squares)))
        else $error("distance too small");

    // square root never runs while the accumulator still takes items
    a_no_fin_open: assert property (@(posedge clk) disable iff (!rst_n)
        sts.fin |-> in_stall)
        else $error("vector end while input open");

endmodule

### sim/tb_euclidean_distance.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_euclidean_distance
// Self-checking bench for the streaming Euclidean distance engine. Element
// pairs are streamed in as vectors. A scoreboard keeps its own running sum of
// squares and predicts the distance and sum for every vector. Each result item
// is checked field by field, in order. Both channels idle at random. The
// receiver once holds off for a long stretch so that the engine backs up into
// its input.
// ============================================================================
module tb_euclidean_distance;

    localparam int                CLK_HALF     = 10;     // 20 ns period
    localparam int                IDLE_PCT     = 11;     // idle cycles per hundred
    localparam int                HOLD_CYCLES  = 400;    // long receiver hold-off
    localparam int                DOG_LIMIT    = 3000;   // cycles with no handshake
    localparam int                DRAIN_CYCLES = 60;     // margin past the last result
    localparam int                RAND_ITEMS   = 520;
    localparam longint unsigned   SUM_TOP      = 64'(ed_pkg::SumMax);

    typedef struct packed {
        logic [ed_pkg::DistW-1:0] root_dist;
        logic [ed_pkg::SumW-1:0]  sumsq;
    } dist_result_t;

    // ------------------------------------------------------------------------
    // Scoreboard: tracks the vector sum as items are accepted and queues the
    // expected result item whenever a last item goes in.
    // ------------------------------------------------------------------------
    class dist_scoreboard;
        longint unsigned acc_sum;
        dist_result_t    expected_q[$];
        int              errors;

        function new();
            acc_sum = 0;
            errors  = 0;
        endfunction

        // floor square root, one result bit at a time from the top
        function logic [ed_pkg::DistW-1:0] floor_root(longint unsigned x);
            longint unsigned root;
            longint unsigned trial;
            root = 0;
            for (int i = ed_pkg::DistW - 1; i >= 0; i--)
            begin
                trial = root | (64'd1 << i);
                if (trial * trial <= x)
                    root = trial;
            end
            return root[ed_pkg::DistW-1:0];
        endfunction

        function void note_pair(logic signed [ed_pkg::ElemW-1:0] a,
                                logic signed [ed_pkg::ElemW-1:0] b,
                                logic is_last);
            int              diff;
            longint unsigned sq;
            dist_result_t    res;
            diff = int'(a) - int'(b);
            if (diff < 0)
                diff = -diff;
            sq = longint'(diff) * longint'(diff);
            if (acc_sum > SUM_TOP - sq)
                acc_sum = SUM_TOP;              // saturate at the register top
            else
                acc_sum = acc_sum + sq;
            if (is_last)
            begin
                res.root_dist = floor_root(acc_sum);
                res.sumsq     = acc_sum[ed_pkg::SumW-1:0];
                expected_q.push_back(res);
                acc_sum = 0;
            end
        endfunction

        function void check_result(logic [ed_pkg::DistW-1:0] dist_val,
                                   logic [ed_pkg::SumW-1:0] sumsq);
            dist_result_t res;
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item: distance %0d sum_squares %0d",
                         $time, dist_val, sumsq);
                return;
            end
            res = expected_q.pop_front();
            if (dist_val !== res.root_dist)
            begin
                errors++;
                $display("%0t: distance mismatch: expected %0d actual %0d",
                         $time, res.root_dist, dist_val);
            end
            if (sumsq !== res.sumsq)
            begin
                errors++;
                $display("%0t: sum_squares mismatch: expected %0d actual %0d",
                         $time, res.sumsq, sumsq);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // DUT connections
    // ------------------------------------------------------------------------
    logic                             clk;
    logic                             rst_n     = 1'b0;
    logic                             in_valid  = 1'b0;
    logic                             in_stall;
    logic signed [ed_pkg::ElemW-1:0]  elem_a    = '0;
    logic signed [ed_pkg::ElemW-1:0]  elem_b    = '0;
    logic                             last      = 1'b0;
    logic                             out_valid;
    logic                             out_stall = 1'b0;
    logic        [ed_pkg::DistW-1:0]  distance;
    logic        [ed_pkg::SumW-1:0]   sum_squares;

    dist_scoreboard sb = new();

    // bench knobs
    logic quiet   = 1'b0;   // no idling on either side while set
    logic hold_go = 1'b0;   // asks the receiver for its long hold-off
    int   rand_items_sent;

    euclidean_distance uut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .elem_a      (elem_a),
        .elem_b      (elem_b),
        .last        (last),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .distance    (distance),
        .sum_squares (sum_squares)
    );

    initial
    begin
        clk = 1'b0;
        forever #CLK_HALF clk = ~clk;
    end

    function automatic logic roll_idle();
        return !quiet && ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // ------------------------------------------------------------------------
    // Sender: optional random gap, then offer the item until it is taken.
    // Acceptance is judged from the values seen at the edge, before any
    // update at that edge lands. in_valid is assigned once per edge at most.
    // ------------------------------------------------------------------------
    task automatic send_pair(input logic signed [ed_pkg::ElemW-1:0] a,
                             input logic signed [ed_pkg::ElemW-1:0] b,
                             input logic is_last);
        while (roll_idle())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        elem_a   <= a;
        elem_b   <= b;
        last     <= is_last;
        @(posedge clk);
        while (in_stall !== 1'b0)
            @(posedge clk);
        sb.note_pair(a, b, is_last);
    endtask

    // element generator; the style mix keeps small, full-range and extreme
    // values all in play
    function automatic logic signed [ed_pkg::ElemW-1:0] pick_elem(int style);
        case (style)
            0:       return 16'($urandom_range(0, 65535));
            1:       return $signed(16'($urandom_range(0, 1023)) - 16'd512);
            2:       return ($urandom_range(0, 1) != 0) ? 16'sh7fff : 16'sh8000;
            default: return 16'($urandom_range(0, 65535));
        endcase
    endfunction

    // one vector of random content; magnitude mode holds elem_b at zero
    task automatic send_vector(input int len, input logic magnitude);
        int style;
        logic signed [ed_pkg::ElemW-1:0] a;
        logic signed [ed_pkg::ElemW-1:0] b;
        style = $urandom_range(0, 3);
        for (int i = 0; i < len; i++)
        begin
            a = pick_elem(style);
            b = magnitude ? 16'sd0 : pick_elem(style);
            send_pair(a, b, i == len - 1);
        end
        rand_items_sent += len;
    endtask

    // ------------------------------------------------------------------------
    // Receiver: checks every result item taken and stalls at random. The
    // long hold-off is counted here once the main flow asks for it.
    // ------------------------------------------------------------------------
    initial
    begin
        int   hold_left;
        logic hold_taken;
        hold_left  = 0;
        hold_taken = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid === 1'b1 && out_stall === 1'b0)
                sb.check_result(distance, sum_squares);
            if (hold_go && !hold_taken)
            begin
                hold_taken = 1'b1;
                hold_left  = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= roll_idle();
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: gives up after too many cycles with no handshake on either
    // channel.
    // ------------------------------------------------------------------------
    initial
    begin
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < DOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("tb_euclidean_distance NOT OK");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main flow
    // ------------------------------------------------------------------------
    initial
    begin
        int len;
        rand_items_sent = 0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // --- directed: single-element vectors at the field extremes ---
        send_pair(16'sh7fff, 16'sh8000, 1'b1);   // largest positive difference
        send_pair(16'sh8000, 16'sh7fff, 1'b1);   // largest negative difference
        send_pair(16'sh0000, 16'sh0000, 1'b1);   // zero distance
        send_pair(16'sh8000, 16'sh8000, 1'b1);   // equal extremes
        send_pair(16'sh0100, 16'sh0000, 1'b1);   // magnitude of 1.0
        send_pair(16'shffff, 16'sh0000, 1'b1);   // magnitude of -1 lsb
        send_pair(16'sh8000, 16'sh0000, 1'b1);   // magnitude of most negative
        send_pair(16'sh0001, 16'shffff, 1'b1);
        send_pair(16'sh5555, 16'shaaaa, 1'b1);   // alternating bit patterns
        send_pair(16'shaaaa, 16'sh5555, 1'b1);
        // --- directed: multi-element vectors, terms before the last item ---
        send_pair(16'sh0300, 16'sh0000, 1'b0);   // 3-4-5 triangle
        send_pair(16'sh0400, 16'sh0000, 1'b1);
        send_pair(16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh7fff, 16'sh8000, 1'b0);
        send_pair(16'sh0000, 16'sh0000, 1'b1);   // last item with no term
        send_pair(16'sh1234, 16'shfedc, 1'b0);
        send_pair(16'sh0000, 16'sh0000, 1'b0);
        send_pair(16'shedcb, 16'sh0123, 1'b1);

        // --- random vectors; mostly short, now and then longer ones ---
        while (rand_items_sent < RAND_ITEMS)
        begin
            // a long stretch with no idling on either side
            quiet = (rand_items_sent >= 150 && rand_items_sent < 300);
            if (rand_items_sent >= 350 && !hold_go)
            begin
                // receiver holds off; short vectors back the engine up
                hold_go <= 1'b1;
                for (int v = 0; v < 30; v++)
                    send_vector($urandom_range(1, 2), $urandom_range(0, 3) == 0);
            end
            if ($urandom_range(0, 19) == 0)
                len = $urandom_range(20, 60);
            else
                len = $urandom_range(1, 8);
            send_vector(len, $urandom_range(0, 3) == 0);
        end
        in_valid <= 1'b0;
        quiet = 1'b0;

        // wait out every expected result, then a margin past the latency
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (sb.errors == 0 && sb.pending() == 0)
            $display("tb_euclidean_distance OK");
        else
            $display("tb_euclidean_distance NOT OK");
        $finish;
    end

endmodule
